[rtl/core/letterbox_bar_detector_top_defines.svh]
// Assertion macros used by the letterbox bar detector checker.
`ifndef LETTERBOX_BAR_DETECTOR_TOP_DEFINES_SVH
`define LETTERBOX_BAR_DETECTOR_TOP_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define LBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbd assertion failed");

// Implication checked in the next cycle, off while reset is asserted.
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbd assertion failed");

// Implication checked in the next cycle, live through reset.
`define LBD_ASSERT_NEXT_LIVE(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbd assertion failed");

`endif

[rtl/core/lbd_pkg.sv]
`default_nettype none
package lbd_pkg;

    localparam int CFG_DIM_W   = 13;
    localparam int LEVEL_W     = 8;
    localparam int OFF_W       = 10;
    localparam int SETTLE_W    = 8;
    localparam int BOT_RUN_W   = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_OFFSET_LIMIT = 1023;

    localparam logic [BOT_RUN_W-1:0] BOTTOM_RUN_MAX = '1;
    localparam logic [SETTLE_W-1:0]  SETTLE_MAX     = '1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DARK_LEVEL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CAP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_FRAMES = 3'd4;

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH   = 13'd1920;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd1080;
    localparam logic [LEVEL_W-1:0]   RST_DARK_LEVEL    = 8'd16;
    localparam logic [OFF_W-1:0]     RST_OFFSET_CAP    = 10'd270;
    localparam logic [SETTLE_W-1:0]  RST_SETTLE_FRAMES = 8'd30;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       start_of_frame;
    } pixel_t;

    typedef struct packed {
        logic [OFF_W-1:0] top_offset;
        logic [OFF_W-1:0] bottom_offset;
        logic             offsets_changed;
    } result_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic [LEVEL_W-1:0]   dark_level;
        logic [OFF_W-1:0]     offset_cap;
        logic [SETTLE_W-1:0]  settle_frames;
    } cfg_t;

endpackage
`default_nettype wire

[rtl/core/letterbox_bar_detector_top.sv]
// Letterbox bar detector: feed captured frames as a raster stream, one pixel per
// request, start_of_frame set on the first pixel. One pixel is taken every clock;
// a frame's result is formed as its last pixel leaves the input register and sits
// in the output register, while later pixels keep flowing in. Only a frame-end pixel
// waits, and only while the previous result is still untaken, so the stream stalls
// just when results back up. The per-pixel state update is combinational between
// the input register and the result register. Write configuration only while idle.
`default_nettype none
module letterbox_bar_detector_top #(
    parameter int MAX_WIDTH    = lbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = lbd_pkg::DEF_MAX_HEIGHT,
    parameter int OFFSET_LIMIT = lbd_pkg::DEF_OFFSET_LIMIT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [lbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire lbd_pkg::pixel_t                    s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output lbd_pkg::result_t                        m_data
);
    import lbd_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid;
    pixel_t  q_data;
    logic    frame_end;
    logic    out_ready;
    logic    fire;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= RST_FRAME_HEIGHT;
            cfg_reg.dark_level    <= RST_DARK_LEVEL;
            cfg_reg.offset_cap    <= RST_OFFSET_CAP;
            cfg_reg.settle_frames <= RST_SETTLE_FRAMES;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_wdata;
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_wdata;
                REG_DARK_LEVEL:    cfg_reg.dark_level    <= cfg_wdata[LEVEL_W-1:0];
                REG_OFFSET_CAP:    cfg_reg.offset_cap    <= cfg_wdata[OFF_W-1:0];
                REG_SETTLE_FRAMES: cfg_reg.settle_frames <= cfg_wdata[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Retire the held pixel unless it closes a frame and the result slot is full
    assign fire = q_valid && (!frame_end || out_ready);

    lbd_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (fire),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    lbd_frame_core #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .OFFSET_LIMIT (OFFSET_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pix       (q_data),
        .fire      (fire),
        .frame_end (frame_end),
        .result    (result)
    );

    lbd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire && frame_end),
        .load_data  (result),
        .load_ready (out_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

[rtl/core/lbd_in_stage.sv]
`default_nettype none
module lbd_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lbd_pkg::pixel_t s_data,
    input  wire logic           advance,
    output logic                q_valid,
    output lbd_pkg::pixel_t     q_data
);
    import lbd_pkg::*;

    logic   valid_reg;
    pixel_t data_reg;

    // Take a new request whenever the held pixel is empty or retires now
    assign s_ready = !valid_reg || advance;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/lbd_frame_core.sv]
`default_nettype none
module lbd_frame_core #(
    parameter int MAX_WIDTH    = lbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = lbd_pkg::DEF_MAX_HEIGHT,
    parameter int OFFSET_LIMIT = lbd_pkg::DEF_OFFSET_LIMIT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lbd_pkg::cfg_t   cfg,
    input  wire lbd_pkg::pixel_t pix,
    input  wire logic            fire,
    output logic                 frame_end,
    output lbd_pkg::result_t     result
);
    import lbd_pkg::*;

    localparam int CPW = $clog2(MAX_WIDTH);
    localparam int RPW = $clog2(MAX_HEIGHT);
    localparam int CW  = (CPW + 1 > CFG_DIM_W) ? CPW + 1 : CFG_DIM_W;
    localparam int RW  = (RPW + 1 > CFG_DIM_W) ? RPW + 1 : CFG_DIM_W;

    logic [CPW-1:0]       column_pos_reg, column_pos_next;
    logic [RPW-1:0]       row_pos_reg, row_pos_next;
    logic                 row_is_black_reg, row_is_black_next;
    logic [OFF_W-1:0]     top_run_reg, top_run_next;
    logic                 top_run_done_reg, top_run_done_next;
    logic [BOT_RUN_W-1:0] bottom_run_reg, bottom_run_next;
    logic [OFF_W-1:0]     accepted_top_reg, accepted_top_next;
    logic [OFF_W-1:0]     accepted_bottom_reg, accepted_bottom_next;
    logic [SETTLE_W-1:0]  settle_count_reg, settle_count_next;

    // Per-frame state as seen by this pixel (start of frame restarts it)
    logic [CPW-1:0]       col_cur;
    logic [RPW-1:0]       row_cur;
    logic                 black_cur;
    logic [OFF_W-1:0]     top_cur;
    logic                 done_cur;
    logic [BOT_RUN_W-1:0] bot_cur;

    logic                 pix_dark;
    logic                 row_black;
    logic                 row_end;
    logic [OFF_W-1:0]     lim;
    logic [OFF_W-1:0]     top_row;
    logic                 done_row;
    logic [BOT_RUN_W-1:0] bot_row;
    logic [OFF_W-1:0]     new_top;
    logic [OFF_W-1:0]     new_bot;
    logic [OFF_W-1:0]     drop_top;
    logic [OFF_W-1:0]     drop_bot;
    logic [SETTLE_W-1:0]  settle_inc;
    logic                 grow;

    assign col_cur   = pix.start_of_frame ? '0 : column_pos_reg;
    assign row_cur   = pix.start_of_frame ? '0 : row_pos_reg;
    assign black_cur = pix.start_of_frame ? 1'b1 : row_is_black_reg;
    assign top_cur   = pix.start_of_frame ? '0 : top_run_reg;
    assign done_cur  = pix.start_of_frame ? 1'b0 : top_run_done_reg;
    assign bot_cur   = pix.start_of_frame ? '0 : bottom_run_reg;

    assign pix_dark = (pix.blue <= cfg.dark_level) && (pix.green <= cfg.dark_level)
                   && (pix.red <= cfg.dark_level);
    assign row_black = black_cur && pix_dark;

    // A zero width acts as one; a position at or past the end closes the row
    assign row_end = (cfg.frame_width == '0)
                  || (CW'(col_cur) + CW'(1) >= CW'(cfg.frame_width))
                  || (CW'(col_cur) + CW'(1) >= CW'(MAX_WIDTH));

    assign frame_end = row_end
                    && ((cfg.frame_height == '0)
                     || (RW'(row_cur) + RW'(1) >= RW'(cfg.frame_height))
                     || (RW'(row_cur) + RW'(1) >= RW'(MAX_HEIGHT)));

    assign lim = (32'(cfg.offset_cap) > OFFSET_LIMIT) ? OFF_W'(OFFSET_LIMIT) : cfg.offset_cap;

    always_comb begin
        top_row  = top_cur;
        done_row = done_cur;
        bot_row  = bot_cur;
        if (row_black) begin
            if (!done_cur && (top_cur < lim)) begin
                top_row = top_cur + OFF_W'(1);
            end
            if (bot_cur != BOTTOM_RUN_MAX) begin
                bot_row = bot_cur + BOT_RUN_W'(1);
            end
        end else begin
            done_row = 1'b1;
            bot_row  = '0;
        end
    end

    assign new_top    = (top_row < lim) ? top_row : lim;
    assign new_bot    = (bot_row < BOT_RUN_W'(lim)) ? OFF_W'(bot_row) : lim;
    assign drop_top   = (new_top < accepted_top_reg) ? new_top : accepted_top_reg;
    assign drop_bot   = (new_bot < accepted_bottom_reg) ? new_bot : accepted_bottom_reg;
    assign grow       = (new_top > drop_top) && (new_bot > drop_bot);
    assign settle_inc = (settle_count_reg != SETTLE_MAX) ? settle_count_reg + SETTLE_W'(1)
                                                         : settle_count_reg;

    always_comb begin
        column_pos_next      = col_cur + CPW'(1);
        row_pos_next         = row_cur;
        row_is_black_next    = row_black;
        top_run_next         = top_cur;
        top_run_done_next    = done_cur;
        bottom_run_next      = bot_cur;
        accepted_top_next    = accepted_top_reg;
        accepted_bottom_next = accepted_bottom_reg;
        settle_count_next    = settle_count_reg;
        if (row_end) begin
            column_pos_next   = '0;
            row_is_black_next = 1'b1;
            if (!frame_end) begin
                row_pos_next      = row_cur + RPW'(1);
                top_run_next      = top_row;
                top_run_done_next = done_row;
                bottom_run_next   = bot_row;
            end else begin
                // Close the frame and restart the per-frame state
                row_pos_next         = '0;
                top_run_next         = '0;
                top_run_done_next    = 1'b0;
                bottom_run_next      = '0;
                accepted_top_next    = drop_top;
                accepted_bottom_next = drop_bot;
                settle_count_next    = '0;
                if (grow) begin
                    if (settle_inc >= cfg.settle_frames) begin
                        accepted_top_next    = new_top;
                        accepted_bottom_next = new_bot;
                    end else begin
                        settle_count_next = settle_inc;
                    end
                end
            end
        end
    end

    assign result.top_offset      = accepted_top_next;
    assign result.bottom_offset   = accepted_bottom_next;
    assign result.offsets_changed = (accepted_top_next != accepted_top_reg)
                                 || (accepted_bottom_next != accepted_bottom_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg      <= '0;
            row_pos_reg         <= '0;
            row_is_black_reg    <= 1'b1;
            top_run_reg         <= '0;
            top_run_done_reg    <= 1'b0;
            bottom_run_reg      <= '0;
            accepted_top_reg    <= '0;
            accepted_bottom_reg <= '0;
            settle_count_reg    <= '0;
        end else if (fire) begin
            column_pos_reg      <= column_pos_next;
            row_pos_reg         <= row_pos_next;
            row_is_black_reg    <= row_is_black_next;
            top_run_reg         <= top_run_next;
            top_run_done_reg    <= top_run_done_next;
            bottom_run_reg      <= bottom_run_next;
            accepted_top_reg    <= accepted_top_next;
            accepted_bottom_reg <= accepted_bottom_next;
            settle_count_reg    <= settle_count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/lbd_out_stage.sv]
`default_nettype none
module lbd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire lbd_pkg::result_t load_data,
    output logic                  load_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lbd_pkg::result_t      m_data
);
    import lbd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign load_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            data_reg <= load_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/lbd_checker.sv]
`default_nettype none
`include "letterbox_bar_detector_top_defines.svh"
module lbd_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire lbd_pkg::result_t m_data
);
    import lbd_pkg::*;

    // Last result taken downstream; the block starts with both offsets at zero
    logic [OFF_W-1:0] prev_top_reg;
    logic [OFF_W-1:0] prev_bot_reg;
    logic             moved;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_top_reg <= '0;
            prev_bot_reg <= '0;
        end else if (m_valid && m_ready) begin
            prev_top_reg <= m_data.top_offset;
            prev_bot_reg <= m_data.bottom_offset;
        end
    end

    assign moved = (m_data.top_offset != prev_top_reg) || (m_data.bottom_offset != prev_bot_reg);

    `LBD_ASSERT_NEXT_LIVE(a_reset_clears_out, aclk, !aresetn, !m_valid)
    `LBD_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `LBD_ASSERT_SAME(a_changed_flag, aclk, aresetn, m_valid, m_data.offsets_changed == moved)
    `LBD_ASSERT_SAME(a_empty_takes_input, aclk, aresetn, !m_valid, s_ready)

endmodule

bind letterbox_bar_detector_top lbd_checker u_lbd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
